// ===== hdl/infix_expression_evaluator_unit_assert.svh =====
// Assertion macros used by the evaluator checker
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define IEE_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("evaluator check failed");

// Consequent must hold in the cycle after the antecedent
`define IEE_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("evaluator check failed");

`endif

// ===== hdl/iee_pkg.sv =====
// Shared types, codes and constants of the expression evaluator
package iee_pkg;

    parameter int STACK_DEPTH = 32;
    parameter int VAL_W       = 64;
    parameter int OP_W        = 3;
    parameter int ST_W        = 4;

    // Operator codes as stored on the operator stack
    typedef enum logic [OP_W-1:0] {
        OP_NONE = 3'd0,
        OP_LP   = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_POW  = 3'd6
    } op_t;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK          = 4'd0;
    localparam logic [ST_W-1:0] ST_BAD_CHAR    = 4'd1;
    localparam logic [ST_W-1:0] ST_PAREN       = 4'd2;
    localparam logic [ST_W-1:0] ST_MISSING     = 4'd3;
    localparam logic [ST_W-1:0] ST_DIV_ZERO    = 4'd4;
    localparam logic [ST_W-1:0] ST_NEG_EXP     = 4'd5;
    localparam logic [ST_W-1:0] ST_TOO_BIG     = 4'd6;
    localparam logic [ST_W-1:0] ST_FINAL_COUNT = 4'd7;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 4'd8;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_CARET = 8'h5E;

    // UTF-8 bytes of no-break space, asterisk operator, zero-width space
    localparam logic [7:0] U8_C2 = 8'hC2;
    localparam logic [7:0] U8_A0 = 8'hA0;
    localparam logic [7:0] U8_E2 = 8'hE2;
    localparam logic [7:0] U8_88 = 8'h88;
    localparam logic [7:0] U8_97 = 8'h97;
    localparam logic [7:0] U8_80 = 8'h80;
    localparam logic [7:0] U8_8B = 8'h8B;

    // Request and response between sequencer and arithmetic unit
    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic            done;
        logic [ST_W-1:0] err;
    } alu_rsp_t;

    // Operator precedence
    function automatic logic [2:0] prec(input op_t op);
        logic [2:0] p;
        case (op)
            OP_POW:          p = 3'd4;
            OP_MUL, OP_DIV:  p = 3'd3;
            OP_ADD, OP_SUB:  p = 3'd2;
            default:         p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/iee_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds when not read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/iee_alu.sv =====
// Multi-cycle 64-bit arithmetic unit: add, subtract, multiply, divide, power
module iee_alu (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  iee_pkg::alu_req_t            req,
    input  logic [iee_pkg::VAL_W-1:0]    a,
    input  logic [iee_pkg::VAL_W-1:0]    b,
    output iee_pkg::alu_rsp_t            rsp,
    output logic [iee_pkg::VAL_W-1:0]    res
);

    typedef enum logic [2:0] {
        AL_IDLE, AL_MUL, AL_PCHK, AL_DIV, AL_DSGN, AL_DONE
    } al_state_t;

    // Where a finished multiply goes
    typedef enum logic [1:0] {
        MR_RES, MR_PR, MR_PB
    } mret_t;

    al_state_t   st_reg, st_next;
    mret_t       mret_reg, mret_next;
    logic [1:0]  mstep_reg, mstep_next;
    logic [63:0] mx_reg, mx_next, my_reg, my_next;
    logic [63:0] macc_reg, macc_next, prod_reg, prod_next;
    logic [63:0] pr_reg, pr_next, base_reg, base_next, e_reg, e_next;
    logic [63:0] num_reg, num_next, rem_reg, rem_next, den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] res_reg, res_next;
    logic [iee_pkg::ST_W-1:0] err_reg, err_next;

    logic [31:0] m_opa, m_opb;
    logic [63:0] mul_out, mul_fin;
    logic [64:0] rem_s, diff;

    // One 32x32 multiplier, operand halves picked by step
    assign m_opa   = (mstep_reg == 2'd2) ? mx_reg[63:32] : mx_reg[31:0];
    assign m_opb   = (mstep_reg == 2'd1) ? my_reg[63:32] : my_reg[31:0];
    assign mul_out = {32'b0, m_opa} * {32'b0, m_opb};
    assign mul_fin = macc_reg + {prod_reg[31:0], 32'b0};

    // Restoring divide step
    assign rem_s = {rem_reg, num_reg[63]};
    assign diff  = rem_s - {1'b0, den_reg};

    always_comb begin
        st_next   = st_reg;
        mret_next = mret_reg;
        mstep_next = mstep_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        macc_next = macc_reg;
        prod_next = prod_reg;
        pr_next   = pr_reg;
        base_next = base_reg;
        e_next    = e_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        err_next  = err_reg;
        case (st_reg)
            AL_IDLE: begin
                if (req.start) begin
                    err_next = iee_pkg::ST_OK;
                    case (req.op)
                        iee_pkg::OP_ADD: begin
                            res_next = a + b;
                            st_next  = AL_DONE;
                        end
                        iee_pkg::OP_SUB: begin
                            res_next = a - b;
                            st_next  = AL_DONE;
                        end
                        iee_pkg::OP_MUL: begin
                            mx_next    = a;
                            my_next    = b;
                            mret_next  = MR_RES;
                            mstep_next = 2'd0;
                            st_next    = AL_MUL;
                        end
                        iee_pkg::OP_DIV: begin
                            if (b == 64'd0) begin
                                err_next = iee_pkg::ST_DIV_ZERO;
                                res_next = 64'd0;
                                st_next  = AL_DONE;
                            end else begin
                                num_next = a[63] ? (64'd0 - a) : a;
                                den_next = b[63] ? (64'd0 - b) : b;
                                rem_next = 64'd0;
                                neg_next = a[63] ^ b[63];
                                cnt_next = 6'd0;
                                st_next  = AL_DIV;
                            end
                        end
                        iee_pkg::OP_POW: begin
                            if (b[63]) begin
                                err_next = iee_pkg::ST_NEG_EXP;
                                res_next = 64'd0;
                                st_next  = AL_DONE;
                            end else begin
                                pr_next   = 64'd1;
                                base_next = a;
                                e_next    = b;
                                st_next   = AL_PCHK;
                            end
                        end
                        default: begin
                            res_next = 64'd0;
                            st_next  = AL_DONE;
                        end
                    endcase
                end
            end
            // Low 64 bits of a 64x64 product from three partial products
            AL_MUL: begin
                case (mstep_reg)
                    2'd0: begin
                        prod_next  = mul_out;
                        mstep_next = 2'd1;
                    end
                    2'd1: begin
                        macc_next  = prod_reg;
                        prod_next  = mul_out;
                        mstep_next = 2'd2;
                    end
                    2'd2: begin
                        macc_next  = mul_fin;
                        prod_next  = mul_out;
                        mstep_next = 2'd3;
                    end
                    default: begin
                        mstep_next = 2'd0;
                        case (mret_reg)
                            MR_PR: begin
                                pr_next   = mul_fin;
                                mx_next   = base_reg;
                                my_next   = base_reg;
                                mret_next = MR_PB;
                            end
                            MR_PB: begin
                                base_next = mul_fin;
                                e_next    = {1'b0, e_reg[63:1]};
                                st_next   = AL_PCHK;
                            end
                            default: begin
                                res_next = mul_fin;
                                st_next  = AL_DONE;
                            end
                        endcase
                    end
                endcase
            end
            // Square-and-multiply, one exponent bit per pass
            AL_PCHK: begin
                mstep_next = 2'd0;
                if (e_reg == 64'd0) begin
                    res_next = pr_reg;
                    st_next  = AL_DONE;
                end else if (e_reg[0]) begin
                    mx_next   = pr_reg;
                    my_next   = base_reg;
                    mret_next = MR_PR;
                    st_next   = AL_MUL;
                end else begin
                    mx_next   = base_reg;
                    my_next   = base_reg;
                    mret_next = MR_PB;
                    st_next   = AL_MUL;
                end
            end
            AL_DIV: begin
                if (!diff[64]) begin
                    rem_next = diff[63:0];
                    num_next = {num_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_s[63:0];
                    num_next = {num_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    st_next = AL_DSGN;
                end
            end
            AL_DSGN: begin
                res_next = neg_reg ? (64'd0 - num_reg) : num_reg;
                st_next  = AL_DONE;
            end
            AL_DONE: begin
                st_next = AL_IDLE;
            end
            default: begin
                st_next = AL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= AL_IDLE;
        end else begin
            st_reg <= st_next;
        end
        mret_reg  <= mret_next;
        mstep_reg <= mstep_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        macc_reg  <= macc_next;
        prod_reg  <= prod_next;
        pr_reg    <= pr_next;
        base_reg  <= base_next;
        e_reg     <= e_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
    end

    assign rsp.done = (st_reg == AL_DONE);
    assign rsp.err  = err_reg;
    assign res      = res_reg;

endmodule

// ===== hdl/infix_expression_evaluator_unit.sv =====
// A dropped CR or multibyte lead byte leaves the block idle; a digit, space or operator byte
// passes the token states, and each operator it pops runs the apply states and the arithmetic
// unit. The final byte adds the closing sequence. A new byte is accepted only in the idle
// state, once the previous one is done, paced by the one read port of each stack RAM and the
// shared multi-cycle arithmetic unit. Reset (aresetn low, synchronous) empties both stacks
// by their counts; no clearing pass. The block resets itself per result.
module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] value, [67:64] status, [71:68] zero
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_TOK, S_TOK2, S_TOK3, S_BIN, S_BIN_RD, S_AP, S_AP1, S_AP2, S_AP3,
        S_CP, S_CP1, S_FIN0, S_FIN1, S_FIN2, S_FIN3, S_FIN3R, S_FIN4, S_FIN5
    } state_t;

    typedef enum logic [1:0] { R_DONE, R_TOK2, R_FIN } bret_t;
    typedef enum logic [1:0] { A_BIN, A_CP, A_FIN } aret_t;

    // Partial multibyte sequence held by the byte cleaner
    typedef enum logic [2:0] {
        PF_NONE, PF_C2, PF_E2, PF_E288, PF_E280, PF_E2CR
    } pf_t;

    state_t       state_reg, state_next;
    bret_t        bret_reg, bret_next;
    aret_t        aret_reg, aret_next;
    pf_t          pf_reg, pf_next;
    iee_pkg::op_t op_reg, op_next, apop_reg, apop_next;
    logic [7:0]   c_reg, c_next;
    logic         last_reg, last_next;
    logic [CNT_W-1:0] opc_reg, opc_next, vc_reg, vc_next;
    logic [62:0]  acc_reg, acc_next;
    logic         active_reg, active_next, big_reg, big_next;
    logic         after_reg, after_next, star_reg, star_next;
    logic         cerr_reg, cerr_next, perr_reg, perr_next, ovf_reg, ovf_next;
    logic [iee_pkg::ST_W-1:0] eerr_reg, eerr_next;
    logic [63:0]  b_reg, b_next;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [63:0]  oval_reg, oval_next;
    logic [iee_pkg::ST_W-1:0] ost_reg, ost_next;

    // RAM ports
    logic                      ow_we, or_re, vw_we, vr_re;
    logic [ADDR_W-1:0]         ow_addr, or_addr, vw_addr, vr_addr;
    logic [iee_pkg::OP_W-1:0]  ow_data, or_data;
    logic [63:0]               vw_data, vr_data;

    iee_pkg::alu_req_t alu_req;
    iee_pkg::alu_rsp_t alu_rsp;
    logic [63:0]       alu_res;

    logic              halted;
    logic [CNT_W-1:0]  opc_m1, vc_m1, vc_m2;
    iee_pkg::op_t      top_op;
    logic              pop;

    // Byte cleaner outputs
    logic       cl_tok, cl_err;
    logic [7:0] cl_c;
    pf_t        cl_pf;

    // Request lines merged after the sequencer case
    logic         pv_req, po_req, ne_req, fin_req;
    logic [63:0]  pv_data;
    iee_pkg::op_t po_op;
    logic [iee_pkg::ST_W-1:0] ne_code;

    // Digit accumulation
    logic [66:0] acc_ext, acc_sum;
    logic        is_digit;

    assign halted = cerr_reg | ovf_reg | perr_reg;
    assign opc_m1 = opc_reg - CNT_W'(1);
    assign vc_m1  = vc_reg - CNT_W'(1);
    assign vc_m2  = vc_reg - CNT_W'(2);
    assign top_op = iee_pkg::op_t'(or_data);
    assign pop    = (top_op != iee_pkg::OP_LP) &&
                    ((op_reg == iee_pkg::OP_POW) ?
                     (iee_pkg::prec(op_reg) <  iee_pkg::prec(top_op)) :
                     (iee_pkg::prec(op_reg) <= iee_pkg::prec(top_op)));

    assign is_digit = (c_reg >= iee_pkg::CH_0) && (c_reg <= iee_pkg::CH_9);
    assign acc_ext  = {4'b0, acc_reg};
    assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {63'b0, c_reg[3:0]};

    // Byte cleaning: multibyte mapping, CR and zero-width space removal
    always_comb begin
        cl_tok = 1'b0;
        cl_err = 1'b0;
        cl_c   = s_tdata;
        cl_pf  = pf_reg;
        case (pf_reg)
            PF_NONE: begin
                if (s_tdata == iee_pkg::U8_C2) begin
                    cl_pf = PF_C2;
                end else if (s_tdata == iee_pkg::U8_E2) begin
                    cl_pf = PF_E2;
                end else if (s_tdata == iee_pkg::CH_CR) begin
                    cl_pf = PF_NONE;
                end else if (!s_tdata[7]) begin
                    cl_tok = 1'b1;
                end else begin
                    cl_err = 1'b1;
                end
            end
            PF_C2: begin
                cl_pf = PF_NONE;
                if (s_tdata == iee_pkg::U8_A0) begin
                    cl_tok = 1'b1;
                    cl_c   = iee_pkg::CH_SP;
                end else begin
                    cl_err = 1'b1;
                end
            end
            PF_E2: begin
                if (s_tdata == iee_pkg::U8_88) begin
                    cl_pf = PF_E288;
                end else if (s_tdata == iee_pkg::U8_80) begin
                    cl_pf = PF_E280;
                end else if (s_tdata == iee_pkg::CH_CR) begin
                    cl_pf = PF_E2CR;
                end else begin
                    cl_pf  = PF_NONE;
                    cl_err = 1'b1;
                end
            end
            PF_E288: begin
                cl_pf = PF_NONE;
                if (s_tdata == iee_pkg::U8_97) begin
                    cl_tok = 1'b1;
                    cl_c   = iee_pkg::CH_STAR;
                end else begin
                    cl_err = 1'b1;
                end
            end
            PF_E280: begin
                if (s_tdata == iee_pkg::U8_8B) begin
                    cl_pf = PF_NONE;
                end else if (s_tdata != iee_pkg::CH_CR) begin
                    cl_pf  = PF_NONE;
                    cl_err = 1'b1;
                end
            end
            default: begin
                if (s_tdata == iee_pkg::U8_80) begin
                    cl_pf = PF_E280;
                end else if (s_tdata != iee_pkg::CH_CR) begin
                    cl_pf  = PF_NONE;
                    cl_err = 1'b1;
                end
            end
        endcase
    end

    // Sequencer. Stack accesses are ordered by state: a read is always issued in a
    // later cycle than the write of the same entry, so no forwarding is needed.
    always_comb begin
        state_next = state_reg;
        bret_next  = bret_reg;
        aret_next  = aret_reg;
        pf_next    = pf_reg;
        op_next    = op_reg;
        apop_next  = apop_reg;
        c_next     = c_reg;
        last_next  = last_reg;
        opc_next   = opc_reg;
        vc_next    = vc_reg;
        acc_next   = acc_reg;
        active_next = active_reg;
        big_next   = big_reg;
        after_next = after_reg;
        star_next  = star_reg;
        cerr_next  = cerr_reg;
        perr_next  = perr_reg;
        ovf_next   = ovf_reg;
        eerr_next  = eerr_reg;
        b_next     = b_reg;
        oval_next  = oval_reg;
        ost_next   = ost_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        ow_we   = 1'b0;
        ow_addr = opc_reg[ADDR_W-1:0];
        ow_data = iee_pkg::OP_W'(iee_pkg::OP_NONE);
        or_re   = 1'b0;
        or_addr = opc_m1[ADDR_W-1:0];
        vw_we   = 1'b0;
        vw_addr = vc_reg[ADDR_W-1:0];
        vw_data = 64'd0;
        vr_re   = 1'b0;
        vr_addr = vc_m1[ADDR_W-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = apop_reg;

        pv_req  = 1'b0;
        pv_data = 64'd0;
        po_req  = 1'b0;
        po_op   = op_reg;
        ne_req  = 1'b0;
        ne_code = iee_pkg::ST_OK;
        fin_req = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pf_next   = cl_pf;
                    last_next = s_tlast;
                    c_next    = cl_c;
                    if (cl_err) begin
                        cerr_next = 1'b1;
                    end
                    if (cl_tok) begin
                        state_next = S_TOK;
                    end else if (s_tlast) begin
                        state_next = S_FIN0;
                    end
                end
            end
            // Resolve a pending '*' against this token
            S_TOK: begin
                if (star_reg) begin
                    star_next = 1'b0;
                    if (c_reg == iee_pkg::CH_STAR) begin
                        op_next   = iee_pkg::OP_POW;
                        bret_next = R_DONE;
                    end else begin
                        op_next   = iee_pkg::OP_MUL;
                        bret_next = R_TOK2;
                    end
                    state_next = S_BIN;
                end else begin
                    state_next = S_TOK2;
                end
            end
            // Digits extend the number; anything else ends it
            S_TOK2: begin
                if (is_digit) begin
                    if (!big_reg) begin
                        if (|acc_sum[66:63]) begin
                            big_next = 1'b1;
                        end else begin
                            acc_next = acc_sum[62:0];
                        end
                    end
                    active_next = 1'b1;
                    state_next  = last_reg ? S_FIN0 : S_IDLE;
                end else begin
                    fin_req    = 1'b1;
                    state_next = S_TOK3;
                end
            end
            S_TOK3: begin
                state_next = last_reg ? S_FIN0 : S_IDLE;
                bret_next  = R_DONE;
                case (c_reg)
                    iee_pkg::CH_SP, iee_pkg::CH_TAB, iee_pkg::CH_LF,
                    iee_pkg::CH_VT, iee_pkg::CH_FF, iee_pkg::CH_CR: begin
                        state_next = last_reg ? S_FIN0 : S_IDLE;
                    end
                    iee_pkg::CH_LPAR: begin
                        po_req     = 1'b1;
                        po_op      = iee_pkg::OP_LP;
                        after_next = 1'b1;
                    end
                    iee_pkg::CH_RPAR: begin
                        after_next = 1'b0;
                        if (!halted) begin
                            state_next = S_CP;
                        end
                    end
                    iee_pkg::CH_PLUS: begin
                        if (!after_reg) begin
                            op_next    = iee_pkg::OP_ADD;
                            state_next = S_BIN;
                        end
                    end
                    iee_pkg::CH_MINUS: begin
                        if (after_reg) begin
                            pv_req = 1'b1;
                        end
                        op_next    = iee_pkg::OP_SUB;
                        state_next = S_BIN;
                    end
                    iee_pkg::CH_STAR: begin
                        star_next  = 1'b1;
                        after_next = 1'b1;
                    end
                    iee_pkg::CH_SLASH: begin
                        op_next    = iee_pkg::OP_DIV;
                        state_next = S_BIN;
                    end
                    iee_pkg::CH_CARET: begin
                        op_next    = iee_pkg::OP_POW;
                        state_next = S_BIN;
                    end
                    default: begin
                        cerr_next = 1'b1;
                    end
                endcase
            end
            // Binary operator: pop while precedence allows, then push
            S_BIN: begin
                after_next = 1'b1;
                if (halted || opc_reg == '0) begin
                    po_req = 1'b1;
                    case (bret_reg)
                        R_TOK2:  state_next = S_TOK2;
                        R_FIN:   state_next = S_FIN2;
                        default: state_next = last_reg ? S_FIN0 : S_IDLE;
                    endcase
                end else begin
                    or_re      = 1'b1;
                    state_next = S_BIN_RD;
                end
            end
            S_BIN_RD: begin
                if (pop) begin
                    opc_next   = opc_m1;
                    apop_next  = top_op;
                    aret_next  = A_BIN;
                    state_next = S_AP;
                end else begin
                    po_req = 1'b1;
                    case (bret_reg)
                        R_TOK2:  state_next = S_TOK2;
                        R_FIN:   state_next = S_FIN2;
                        default: state_next = last_reg ? S_FIN0 : S_IDLE;
                    endcase
                end
            end
            // Apply an operator to the top two values
            S_AP: begin
                if (vc_reg < CNT_W'(2)) begin
                    ne_req  = 1'b1;
                    ne_code = iee_pkg::ST_MISSING;
                    case (aret_reg)
                        A_CP:    state_next = S_CP;
                        A_FIN:   state_next = S_FIN3;
                        default: state_next = S_BIN;
                    endcase
                end else begin
                    vr_re      = 1'b1;
                    state_next = S_AP1;
                end
            end
            S_AP1: begin
                b_next     = vr_data;
                vr_re      = 1'b1;
                vr_addr    = vc_m2[ADDR_W-1:0];
                state_next = S_AP2;
            end
            S_AP2: begin
                alu_req.start = 1'b1;
                state_next    = S_AP3;
            end
            S_AP3: begin
                if (alu_rsp.done) begin
                    vw_we   = 1'b1;
                    vw_addr = vc_m2[ADDR_W-1:0];
                    vw_data = alu_res;
                    vc_next = vc_m1;
                    if (alu_rsp.err != iee_pkg::ST_OK) begin
                        ne_req  = 1'b1;
                        ne_code = alu_rsp.err;
                    end
                    case (aret_reg)
                        A_CP:    state_next = S_CP;
                        A_FIN:   state_next = S_FIN3;
                        default: state_next = S_BIN;
                    endcase
                end
            end
            // Closing parenthesis: unwind to the matching '('
            S_CP: begin
                if (opc_reg == '0) begin
                    perr_next  = 1'b1;
                    state_next = last_reg ? S_FIN0 : S_IDLE;
                end else begin
                    or_re      = 1'b1;
                    state_next = S_CP1;
                end
            end
            S_CP1: begin
                opc_next = opc_m1;
                if (top_op == iee_pkg::OP_LP) begin
                    state_next = last_reg ? S_FIN0 : S_IDLE;
                end else begin
                    apop_next  = top_op;
                    aret_next  = A_CP;
                    state_next = S_AP;
                end
            end
            // End of expression
            S_FIN0: begin
                fin_req    = 1'b1;
                state_next = S_FIN1;
            end
            S_FIN1: begin
                if (star_reg) begin
                    star_next  = 1'b0;
                    op_next    = iee_pkg::OP_MUL;
                    bret_next  = R_FIN;
                    state_next = S_BIN;
                end else begin
                    state_next = S_FIN2;
                end
            end
            S_FIN2: begin
                if (pf_reg != PF_NONE) begin
                    cerr_next = 1'b1;
                end
                state_next = S_FIN3;
            end
            S_FIN3: begin
                if (halted || opc_reg == '0) begin
                    state_next = S_FIN4;
                end else begin
                    or_re      = 1'b1;
                    state_next = S_FIN3R;
                end
            end
            S_FIN3R: begin
                if (top_op == iee_pkg::OP_LP) begin
                    perr_next  = 1'b1;
                    state_next = S_FIN4;
                end else begin
                    opc_next   = opc_m1;
                    apop_next  = top_op;
                    aret_next  = A_FIN;
                    state_next = S_AP;
                end
            end
            S_FIN4: begin
                if (!halted && vc_reg != CNT_W'(1)) begin
                    ne_req  = 1'b1;
                    ne_code = iee_pkg::ST_FINAL_COUNT;
                end
                vr_re      = 1'b1;
                vr_addr    = '0;
                state_next = S_FIN5;
            end
            // Load the result register and return to reset state
            S_FIN5: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    oval_next     = 64'd0;
                    if (cerr_reg) begin
                        ost_next = iee_pkg::ST_BAD_CHAR;
                    end else if (ovf_reg) begin
                        ost_next = iee_pkg::ST_OVERFLOW;
                    end else if (perr_reg) begin
                        ost_next = iee_pkg::ST_PAREN;
                    end else if (eerr_reg != iee_pkg::ST_OK) begin
                        ost_next = eerr_reg;
                    end else begin
                        ost_next  = iee_pkg::ST_OK;
                        oval_next = vr_data;
                    end
                    opc_next    = '0;
                    vc_next     = '0;
                    acc_next    = '0;
                    active_next = 1'b0;
                    big_next    = 1'b0;
                    after_next  = 1'b1;
                    star_next   = 1'b0;
                    pf_next     = PF_NONE;
                    cerr_next   = 1'b0;
                    perr_next   = 1'b0;
                    eerr_next   = iee_pkg::ST_OK;
                    ovf_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Number completion
        if (fin_req && active_reg) begin
            if (big_reg) begin
                ne_req  = 1'b1;
                ne_code = iee_pkg::ST_TOO_BIG;
            end else begin
                pv_data = {1'b0, acc_reg};
            end
            pv_req      = 1'b1;
            acc_next    = '0;
            active_next = 1'b0;
            big_next    = 1'b0;
            after_next  = 1'b0;
        end

        // Value push with overflow check
        if (pv_req && !halted) begin
            if (vc_reg == FULL) begin
                ovf_next = 1'b1;
            end else begin
                vw_we   = 1'b1;
                vw_addr = vc_reg[ADDR_W-1:0];
                vw_data = pv_data;
                vc_next = vc_reg + CNT_W'(1);
            end
        end

        // Operator push with overflow check
        if (po_req && !halted) begin
            if (opc_reg == FULL) begin
                ovf_next = 1'b1;
            end else begin
                ow_we    = 1'b1;
                ow_addr  = opc_reg[ADDR_W-1:0];
                ow_data  = po_op;
                opc_next = opc_reg + CNT_W'(1);
            end
        end

        // First evaluation error wins
        if (ne_req && eerr_reg == iee_pkg::ST_OK) begin
            eerr_next = ne_code;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bret_reg     <= R_DONE;
            aret_reg     <= A_BIN;
            pf_reg       <= PF_NONE;
            last_reg     <= 1'b0;
            opc_reg      <= '0;
            vc_reg       <= '0;
            acc_reg      <= '0;
            active_reg   <= 1'b0;
            big_reg      <= 1'b0;
            after_reg    <= 1'b1;
            star_reg     <= 1'b0;
            cerr_reg     <= 1'b0;
            perr_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            eerr_reg     <= iee_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bret_reg     <= bret_next;
            aret_reg     <= aret_next;
            pf_reg       <= pf_next;
            last_reg     <= last_next;
            opc_reg      <= opc_next;
            vc_reg       <= vc_next;
            acc_reg      <= acc_next;
            active_reg   <= active_next;
            big_reg      <= big_next;
            after_reg    <= after_next;
            star_reg     <= star_next;
            cerr_reg     <= cerr_next;
            perr_reg     <= perr_next;
            ovf_reg      <= ovf_next;
            eerr_reg     <= eerr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg   <= op_next;
        apop_reg <= apop_next;
        c_reg    <= c_next;
        b_reg    <= b_next;
        oval_reg <= oval_next;
        ost_reg  <= ost_next;
    end

    // Operator stack
    iee_ram #(
        .WIDTH (iee_pkg::OP_W),
        .DEPTH (STACK_DEPTH)
    ) u_op_ram (
        .aclk  (aclk),
        .we    (ow_we),
        .waddr (ow_addr),
        .wdata (ow_data),
        .re    (or_re),
        .raddr (or_addr),
        .rdata (or_data)
    );

    // Value stack
    iee_ram #(
        .WIDTH (iee_pkg::VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (vw_we),
        .waddr (vw_addr),
        .wdata (vw_data),
        .re    (vr_re),
        .raddr (vr_addr),
        .rdata (vr_data)
    );

    iee_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (vr_data),
        .b       (b_reg),
        .rsp     (alu_rsp),
        .res     (alu_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, ost_reg, oval_reg};

endmodule

// ===== hdl/iee_chk.sv =====
// Port-level checker for the evaluator, bound to the top level
`include "infix_expression_evaluator_unit_assert.svh"

module iee_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A held result keeps its contents
    `IEE_CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Error results carry a zero value
    `IEE_CHK_NOW(a_err_zero, m_tvalid && m_tdata[67:64] != iee_pkg::ST_OK, m_tdata[63:0] == 64'd0)
    // Status stays within the defined codes, padding is zero
    `IEE_CHK_NOW(a_status_rng, m_tvalid, m_tdata[67:64] <= iee_pkg::ST_OVERFLOW && m_tdata[71:68] == 4'd0)
    // The final byte always starts the closing sequence
    `IEE_CHK_NEXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind infix_expression_evaluator_unit iee_chk u_iee_chk (.*);

// ===== tb/sv/infix_expression_evaluator_unit_test.sv =====
// Self-checking testbench of the streaming infix expression evaluator
module infix_expression_evaluator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 2000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } byte_t;

    typedef struct packed {
        logic [63:0]              value;
        logic [iee_pkg::ST_W-1:0] status;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    infix_expression_evaluator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    byte_t   text_q[$];
    answer_t answer_q[$];
    int      errors;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;

    // Evaluator state mirrored in the testbench
    iee_pkg::op_t ops[iee_pkg::STACK_DEPTH];
    int           op_cnt;
    logic [63:0]  vals[iee_pkg::STACK_DEPTH];
    int           val_cnt;
    logic [63:0]  acc;
    bit           in_num, too_big, after_op, star_wait;
    int           utf_state;
    bit           bad_char, bad_paren, ovf;
    logic [3:0]   eval_err;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void clear_eval();
        op_cnt = 0; val_cnt = 0; acc = '0;
        in_num = 0; too_big = 0; after_op = 1; star_wait = 0;
        utf_state = 0; bad_char = 0; bad_paren = 0; ovf = 0; eval_err = iee_pkg::ST_OK;
    endfunction

    function automatic bit stopped();
        return bad_char || ovf || bad_paren;
    endfunction

    function automatic void note_err(logic [3:0] code);
        if (eval_err == iee_pkg::ST_OK) eval_err = code;
    endfunction

    function automatic void push_value(logic [63:0] v);
        if (stopped()) return;
        if (val_cnt >= iee_pkg::STACK_DEPTH) begin
            ovf = 1;
            return;
        end
        vals[val_cnt] = v;
        val_cnt++;
    endfunction

    function automatic void push_oper(iee_pkg::op_t op);
        if (stopped()) return;
        if (op_cnt >= iee_pkg::STACK_DEPTH) begin
            ovf = 1;
            return;
        end
        ops[op_cnt] = op;
        op_cnt++;
    endfunction

    function automatic int rank(iee_pkg::op_t op);
        case (op)
            iee_pkg::OP_POW:                  return 4;
            iee_pkg::OP_MUL, iee_pkg::OP_DIV: return 3;
            iee_pkg::OP_ADD, iee_pkg::OP_SUB: return 2;
            default:                          return 0;
        endcase
    endfunction

    // Pop two values, combine, push the result
    function automatic void reduce(iee_pkg::op_t op);
        logic signed [63:0] a, b, r;
        logic [63:0] base, e, p;
        if (val_cnt < 2) begin
            note_err(iee_pkg::ST_MISSING);
            return;
        end
        b = vals[val_cnt-1];
        a = vals[val_cnt-2];
        val_cnt -= 2;
        r = '0;
        case (op)
            iee_pkg::OP_ADD: r = a + b;
            iee_pkg::OP_SUB: r = a - b;
            iee_pkg::OP_MUL: r = a * b;
            iee_pkg::OP_DIV: begin
                if (b == 0) note_err(iee_pkg::ST_DIV_ZERO);
                else if (a == {1'b1, 63'd0} && b == -64'sd1) r = a;
                else r = a / b;
            end
            iee_pkg::OP_POW: begin
                if (b < 0) note_err(iee_pkg::ST_NEG_EXP);
                else begin
                    base = a; e = b; p = 64'd1;
                    while (e != 0) begin
                        if (e[0]) p = p * base;
                        base = base * base;
                        e = e >> 1;
                    end
                    r = p;
                end
            end
            default: r = '0;
        endcase
        vals[val_cnt] = r;
        val_cnt++;
    endfunction

    function automatic void binary(iee_pkg::op_t op);
        iee_pkg::op_t top;
        bit pop;
        after_op = 1;
        if (stopped()) return;
        while (op_cnt > 0) begin
            top = ops[op_cnt-1];
            if (top == iee_pkg::OP_LP) break;
            pop = (op == iee_pkg::OP_POW) ? (rank(op) < rank(top)) : (rank(op) <= rank(top));
            if (!pop) break;
            op_cnt--;
            reduce(top);
        end
        push_oper(op);
    endfunction

    function automatic void end_number();
        if (!in_num) return;
        if (too_big) begin
            note_err(iee_pkg::ST_TOO_BIG);
            push_value('0);
        end else begin
            push_value(acc);
        end
        acc = '0; in_num = 0; too_big = 0; after_op = 0;
    endfunction

    function automatic void token(logic [7:0] c);
        logic [63:0] d;
        if (star_wait) begin
            star_wait = 0;
            if (c == iee_pkg::CH_STAR) begin
                binary(iee_pkg::OP_POW);
                return;
            end
            binary(iee_pkg::OP_MUL);
        end
        if (c >= iee_pkg::CH_0 && c <= iee_pkg::CH_9) begin
            d = 64'(c - iee_pkg::CH_0);
            if (!too_big) begin
                if (acc > (64'h7FFF_FFFF_FFFF_FFFF - d) / 10) too_big = 1;
                else acc = acc * 10 + d;
            end
            in_num = 1;
            return;
        end
        end_number();
        case (c)
            iee_pkg::CH_SP, iee_pkg::CH_TAB, iee_pkg::CH_LF,
            iee_pkg::CH_VT, iee_pkg::CH_FF, iee_pkg::CH_CR: ;
            iee_pkg::CH_LPAR: begin
                push_oper(iee_pkg::OP_LP);
                after_op = 1;
            end
            iee_pkg::CH_RPAR: begin
                after_op = 0;
                if (!stopped()) begin
                    while (op_cnt > 0 && ops[op_cnt-1] != iee_pkg::OP_LP) begin
                        op_cnt--;
                        reduce(ops[op_cnt]);
                    end
                    if (op_cnt > 0) op_cnt--;
                    else bad_paren = 1;
                end
            end
            iee_pkg::CH_PLUS:  if (!after_op) binary(iee_pkg::OP_ADD);
            iee_pkg::CH_MINUS: begin
                if (after_op) push_value('0);
                binary(iee_pkg::OP_SUB);
            end
            iee_pkg::CH_STAR: begin
                star_wait = 1;
                after_op = 1;
            end
            iee_pkg::CH_SLASH: binary(iee_pkg::OP_DIV);
            iee_pkg::CH_CARET: binary(iee_pkg::OP_POW);
            default:  bad_char = 1;
        endcase
    endfunction

    // UTF-8 cleanup ahead of tokenizing
    function automatic void clean(logic [7:0] b);
        case (utf_state)
            0: begin
                if (b == iee_pkg::U8_C2) utf_state = 1;
                else if (b == iee_pkg::U8_E2) utf_state = 2;
                else if (b == iee_pkg::CH_CR) ;
                else if (b < 8'h80) token(b);
                else bad_char = 1;
            end
            1: begin
                utf_state = 0;
                if (b == iee_pkg::U8_A0) token(iee_pkg::CH_SP);
                else bad_char = 1;
            end
            2: begin
                if (b == iee_pkg::U8_88) utf_state = 3;
                else if (b == iee_pkg::U8_80) utf_state = 4;
                else if (b == iee_pkg::CH_CR) utf_state = 5;
                else begin
                    utf_state = 0;
                    bad_char = 1;
                end
            end
            3: begin
                utf_state = 0;
                if (b == iee_pkg::U8_97) token(iee_pkg::CH_STAR);
                else bad_char = 1;
            end
            4: begin
                if (b == iee_pkg::U8_8B) utf_state = 0;
                else if (b != iee_pkg::CH_CR) begin
                    utf_state = 0;
                    bad_char = 1;
                end
            end
            default: begin
                if (b == iee_pkg::U8_80) utf_state = 4;
                else if (b != iee_pkg::CH_CR) begin
                    utf_state = 0;
                    bad_char = 1;
                end
            end
        endcase
    endfunction

    // Feed one accepted byte; queue the answer on the last one
    function automatic void evaluate_byte(byte_t it);
        answer_t ans;
        iee_pkg::op_t top;
        clean(it.ch);
        if (!it.last) return;
        end_number();
        if (star_wait) begin
            star_wait = 0;
            binary(iee_pkg::OP_MUL);
        end
        if (utf_state != 0) bad_char = 1;
        while (!stopped() && op_cnt > 0) begin
            top = ops[op_cnt-1];
            if (top == iee_pkg::OP_LP) begin
                bad_paren = 1;
                break;
            end
            op_cnt--;
            reduce(top);
        end
        if (!stopped() && val_cnt != 1) note_err(iee_pkg::ST_FINAL_COUNT);
        ans.value = '0;
        if (bad_char) ans.status = iee_pkg::ST_BAD_CHAR;
        else if (ovf) ans.status = iee_pkg::ST_OVERFLOW;
        else if (bad_paren) ans.status = iee_pkg::ST_PAREN;
        else if (eval_err != iee_pkg::ST_OK) ans.status = eval_err;
        else begin
            ans.status = iee_pkg::ST_OK;
            ans.value = vals[0];
        end
        answer_q.insert(answer_q.size(), ans);
        clear_eval();
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Stimulus builders
    task automatic add_text(string s);
        byte_t it;
        for (int i = 0; i < s.len(); i++) begin
            it.ch = s[i];
            it.last = (i == s.len() - 1);
            text_q.insert(text_q.size(), it);
        end
    endtask

    task automatic add_bytes(byte unsigned bs[]);
        byte_t it;
        foreach (bs[i]) begin
            it.ch = bs[i];
            it.last = (i == bs.size() - 1);
            text_q.insert(text_q.size(), it);
        end
    endtask

    function automatic string rand_number();
        string s;
        int n;
        s = "";
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(18, 21) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(iee_pkg::CH_0 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_oper();
        case ($urandom_range(0, 7))
            0, 1: return "+";
            2, 3: return "-";
            4:    return "*";
            5:    return "/";
            6:    return "^";
            default: return "**";
        endcase
    endfunction

    function automatic string rand_expr(int depth);
        string s;
        int terms;
        s = "";
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) s = {s, ($urandom_range(0, 3) == 0) ? " " : "", rand_oper()};
            if ($urandom_range(0, 5) == 0) s = {s, "-"};
            if (depth > 0 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(depth - 1), ")"};
            else s = {s, rand_number()};
        end
        return s;
    endfunction

    // Random expression, sometimes damaged or noisy
    task automatic add_random_expr();
        string s;
        int k;
        byte_t it;
        s = rand_expr(3);
        k = $urandom_range(0, 99);
        if (k < 6) begin
            s[$urandom_range(0, s.len() - 1)] = byte'($urandom_range(0, 255));
        end else if (k < 10) begin
            s = {s, ")"};
        end else if (k < 13) begin
            s = {"(", s};
        end
        if (k >= 13 && k < 20) begin
            for (int i = 0; i < s.len(); i++) begin
                it.ch = s[i];
                it.last = 0;
                text_q.insert(text_q.size(), it);
                case ($urandom_range(0, 9))
                    0: add_bytes('{iee_pkg::U8_C2, iee_pkg::U8_A0, iee_pkg::CH_SP});
                    1: add_bytes('{iee_pkg::U8_E2, iee_pkg::CH_CR, iee_pkg::U8_80,
                                   iee_pkg::U8_8B, iee_pkg::CH_SP});
                    2: add_bytes('{iee_pkg::CH_CR, iee_pkg::CH_TAB});
                    default: ;
                endcase
                if (text_q[$].ch == iee_pkg::CH_SP && text_q[$].last) text_q[$].last = 0;
            end
            it.ch = iee_pkg::CH_SP;
            it.last = 1;
            text_q.insert(text_q.size(), it);
        end else begin
            add_text(s);
        end
    endtask

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                evaluate_byte('{ch: s_tdata, last: s_tlast});
                void'(text_q.pop_front());
            end
            if (text_q.size() > 0 &&
                ((s_tvalid && !s_tready) || $urandom_range(0, 99) >= send_idle_pct)) begin
                if (s_tvalid && s_tready) begin
                    if (text_q.size() > 0) begin
                        s_tvalid <= 1'b1;
                        s_tdata <= text_q[0].ch;
                        s_tlast <= text_q[0].last;
                    end else s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= text_q[0].ch;
                    s_tlast <= text_q[0].last;
                end
            end else if (!(s_tvalid && !s_tready)) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver with random stalls and a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor and checker
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
            end else begin
                want = answer_q.pop_front();
                if (m_tdata[63:0] !== want.value)
                    report_mismatch("value", m_tdata[63:0], want.value);
                if (m_tdata[67:64] !== want.status)
                    report_mismatch("status", 64'(m_tdata[67:64]), 64'(want.status));
                if (m_tdata[71:68] !== 4'd0)
                    report_mismatch("pad", 64'(m_tdata[71:68]), 64'd0);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic wait_empty();
        while (text_q.size() > 0 || answer_q.size() > 0) @(posedge aclk);
    endtask

    initial begin
        string deep;
        errors = 0; idle_cycles = 0; hold_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        clear_eval();
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed expressions
        add_text("1+2*3");
        add_text("2**3**2");
        add_text("2^62-(-5)/2");
        add_text("9223372036854775807+1");
        add_text("9223372036854775808");
        add_text("(0-9223372036854775807-1)/-1");
        add_text("7/0");
        add_text("2^-1");
        add_text("+3*-4");
        add_text("1+");
        add_text("1 2");
        add_text("(1+2");
        add_text("1)");
        add_text("");
        add_text(" ");
        add_text("3*");
        add_text("4 x");
        add_text("\t\n\v\f5\r");
        add_bytes('{iee_pkg::CH_0 + 8'd6, iee_pkg::U8_E2, iee_pkg::U8_88, iee_pkg::U8_97,
                    iee_pkg::CH_0 + 8'd7});
        add_bytes('{iee_pkg::CH_0 + 8'd1, iee_pkg::U8_C2, iee_pkg::U8_A0, iee_pkg::CH_PLUS,
                    iee_pkg::U8_E2, iee_pkg::CH_CR, iee_pkg::U8_80, iee_pkg::CH_CR,
                    iee_pkg::U8_8B, iee_pkg::CH_0 + 8'd2});
        add_bytes('{iee_pkg::CH_0 + 8'd1, iee_pkg::U8_E2, iee_pkg::U8_88, iee_pkg::CH_CR,
                    iee_pkg::U8_97});
        add_bytes('{iee_pkg::CH_0 + 8'd1, iee_pkg::U8_C2});
        add_bytes('{8'hFF});
        deep = "";
        for (int i = 0; i < 34; i++) deep = {deep, "("};
        add_text({deep, "1"});
        deep = "1";
        for (int i = 0; i < 33; i++) deep = {deep, "+1"};
        add_text(deep);
        wait_empty();

        // Random phases with different idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            while (text_q.size() < 310) add_random_expr();
            if (ph == 2) hold_cycles = 3000;
            wait_empty();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/iee_pkg.sv
hdl/iee_ram.sv
hdl/iee_alu.sv
hdl/infix_expression_evaluator_unit.sv
hdl/iee_chk.sv
tb/sv/infix_expression_evaluator_unit_test.sv
